// ===== hw/rtl/lwt_pkg.sv =====
// Shared types, codes and helpers for the line whitespace trimmer.
// No dependencies; imported by lwt_ctrl, lwt_out_reg and line_whitespace_trimmer.
`default_nettype none

package lwt_pkg;

  localparam int PENDING_DEPTH_DEF = 32;
  localparam int COUNT_WIDTH_DEF   = 32;

  localparam logic [15:0] CODE_CR = 16'h000D;
  localparam logic [15:0] CODE_LF = 16'h000A;

  typedef enum logic [1:0] {
    MODE_IDLE,
    MODE_LEAD,
    MODE_BODY,
    MODE_BREAK
  } line_mode_t;

  typedef enum logic [1:0] {
    ST_ACCEPT,
    ST_FLUSH,
    ST_CHAR,
    ST_SUM
  } seq_state_t;

  typedef struct packed {
    logic        is_summary;
    logic [15:0] character;
    logic [31:0] removed_count;
    logic [31:0] touched_lines;
    logic [31:0] segment_count;
    logic        pending_overflow;
    logic        last_result;
  } result_t;

  function automatic logic is_space(input logic [15:0] c, input logic uni);
    logic ascii_ws;
    logic uni_ws;
    ascii_ws = c inside {16'h0009, 16'h000B, 16'h000C, 16'h0020};
    uni_ws   = c inside {16'h00A0, 16'h1680, 16'h202F, 16'h205F, 16'h3000,
                         [16'h2000:16'h200A]};
    return ascii_ws || (uni && uni_ws);
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lwt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Standalone; holds the pending whitespace store.
`default_nettype none

module lwt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  wire logic                                    clk,
  input  wire logic                                    wr_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                        wr_data,
  input  wire logic                                    rd_en,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/lwt_out_reg.sv =====
// Result output register with valid/stall handshake.
// Depends on lwt_pkg for the result struct.
`default_nettype none

module lwt_out_reg (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             load,
  input  wire lwt_pkg::result_t din,
  input  wire logic             out_stall,
  output logic                  out_valid,
  output lwt_pkg::result_t      dout,
  output logic                  free
);

  import lwt_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t data_r;

  assign free = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (!out_stall) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= din;
    end
  end

  assign out_valid = valid_r;
  assign dout      = data_r;

endmodule

`default_nettype wire

// ===== hw/rtl/lwt_ctrl.sv =====
// Sequencer of the trimmer: line mode, counters, pending store read/modify/write.
// Depends on lwt_pkg; drives the pending RAM and the output register.
`default_nettype none

module lwt_ctrl #(
  parameter int PENDING_DEPTH = lwt_pkg::PENDING_DEPTH_DEF,
  parameter int COUNT_WIDTH   = lwt_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_wr_en,
  input  wire logic                  cfg_wr_data,
  input  wire logic                  in_valid,
  input  wire logic                  in_char_valid,
  input  wire logic [15:0]           in_character,
  input  wire logic                  in_end_of_text,
  output logic                       in_stall,
  input  wire logic                  out_free,
  output logic                       res_load,
  output lwt_pkg::result_t           res,
  output logic                       ram_wr_en,
  output logic [((PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1)-1:0] ram_wr_addr,
  output logic [15:0]                ram_wr_data,
  output logic                       ram_rd_en,
  output logic [((PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1)-1:0] ram_rd_addr,
  input  wire logic [15:0]           ram_rd_data
);

  import lwt_pkg::*;

  localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int FW = $clog2(PENDING_DEPTH + 1);
  localparam int CW = COUNT_WIDTH;
  localparam int SW = COUNT_WIDTH + 1;

  function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] v,
                                            input logic [FW-1:0] n);
    logic [SW-1:0] s;
    s = {1'b0, v} + SW'(n);
    return s[CW] ? {CW{1'b1}} : s[CW-1:0];
  endfunction

  seq_state_t state_r,   state_nxt;
  line_mode_t mode_r,    mode_nxt;
  logic [FW-1:0] fill_r,    fill_nxt;
  logic          trimmed_r, trimmed_nxt;
  logic [CW-1:0] removed_r, removed_nxt;
  logic [CW-1:0] touched_r, touched_nxt;
  logic [CW-1:0] segment_r, segment_nxt;
  logic          overflow_r, overflow_nxt;
  logic          uni_r;
  logic [AW-1:0] idx_r,     idx_nxt;
  logic [15:0]   char_r,    char_nxt;
  logic          eot_r,     eot_nxt;

  logic          accept;
  logic          is_brk;
  logic          ws;
  logic          seg_start;
  line_mode_t    mode_a;
  logic          trim_base;
  logic          store_full;
  logic [FW-1:0] note_n;
  logic [CW-1:0] removed_n;
  logic [CW-1:0] touched_n;
  logic          trimmed_n;

  assign in_stall   = !(state_r == ST_ACCEPT && out_free);
  assign accept     = (state_r == ST_ACCEPT) && in_valid && out_free;
  assign is_brk     = (in_character == CODE_CR) || (in_character == CODE_LF);
  assign ws         = is_space(in_character, uni_r);
  assign store_full = (fill_r == FW'(PENDING_DEPTH));

  always_comb begin
    seg_start = 1'b0;
    if (state_r == ST_ACCEPT && in_char_valid) begin
      if (is_brk) begin
        seg_start = (mode_r == MODE_IDLE);
      end else begin
        seg_start = (mode_r == MODE_IDLE) || (mode_r == MODE_BREAK);
      end
    end
    mode_a    = (seg_start && !is_brk) ? MODE_LEAD : mode_r;
    trim_base = seg_start ? 1'b0 : trimmed_r;

    note_n = '0;
    case (state_r)
      ST_ACCEPT: begin
        if (in_char_valid && is_brk) begin
          note_n = fill_r;
        end else if (in_char_valid && ws && (mode_a == MODE_LEAD || store_full)) begin
          note_n = FW'(1);
        end
      end
      ST_SUM: begin
        note_n = fill_r;
      end
      default: begin
        note_n = '0;
      end
    endcase

    removed_n = sat_add(removed_r, note_n);
    touched_n = (note_n != '0 && !trim_base) ? sat_add(touched_r, FW'(1)) : touched_r;
    trimmed_n = trim_base || (note_n != '0);
  end

  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    fill_nxt     = fill_r;
    trimmed_nxt  = trimmed_r;
    removed_nxt  = removed_r;
    touched_nxt  = touched_r;
    segment_nxt  = segment_r;
    overflow_nxt = overflow_r;
    idx_nxt      = idx_r;
    char_nxt     = char_r;
    eot_nxt      = eot_r;
    res_load     = 1'b0;
    res          = '0;
    ram_wr_en    = 1'b0;
    ram_wr_addr  = fill_r[AW-1:0];
    ram_wr_data  = in_character;
    ram_rd_en    = 1'b0;
    ram_rd_addr  = '0;

    case (state_r)
      ST_ACCEPT: begin
        if (accept) begin
          removed_nxt = removed_n;
          touched_nxt = touched_n;
          trimmed_nxt = trimmed_n;
          if (seg_start) begin
            segment_nxt = sat_add(segment_r, FW'(1));
          end
          if (in_end_of_text) begin
            state_nxt = ST_SUM;
          end
          if (in_char_valid) begin
            if (is_brk) begin
              fill_nxt      = '0;
              mode_nxt      = MODE_BREAK;
              res_load      = 1'b1;
              res.character = in_character;
            end else if (ws) begin
              mode_nxt = mode_a;
              if (mode_a != MODE_LEAD) begin
                if (store_full) begin
                  overflow_nxt = 1'b1;
                end else begin
                  ram_wr_en = 1'b1;
                  fill_nxt  = fill_r + FW'(1);
                end
              end
            end else begin
              mode_nxt = MODE_BODY;
              if (fill_r != '0) begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = '0;
                idx_nxt     = '0;
                char_nxt    = in_character;
                eot_nxt     = in_end_of_text;
                state_nxt   = ST_FLUSH;
              end else begin
                res_load      = 1'b1;
                res.character = in_character;
              end
            end
          end
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          res_load      = 1'b1;
          res.character = ram_rd_data;
          if (FW'(idx_r) + FW'(1) == fill_r) begin
            state_nxt = ST_CHAR;
          end else begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = idx_r + AW'(1);
            idx_nxt     = idx_r + AW'(1);
          end
        end
      end
      ST_CHAR: begin
        if (out_free) begin
          res_load      = 1'b1;
          res.character = char_r;
          fill_nxt      = '0;
          state_nxt     = eot_r ? ST_SUM : ST_ACCEPT;
        end
      end
      ST_SUM: begin
        if (out_free) begin
          res_load             = 1'b1;
          res.is_summary       = 1'b1;
          res.removed_count    = 32'(removed_n);
          res.touched_lines    = 32'(touched_n);
          res.segment_count    = 32'(segment_r);
          res.pending_overflow = overflow_r;
          res.last_result      = 1'b1;
          mode_nxt     = MODE_IDLE;
          fill_nxt     = '0;
          trimmed_nxt  = 1'b0;
          removed_nxt  = '0;
          touched_nxt  = '0;
          segment_nxt  = '0;
          overflow_nxt = 1'b0;
          state_nxt    = ST_ACCEPT;
        end
      end
      default: begin
        state_nxt = ST_ACCEPT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_ACCEPT;
      mode_r     <= MODE_IDLE;
      fill_r     <= '0;
      trimmed_r  <= 1'b0;
      removed_r  <= '0;
      touched_r  <= '0;
      segment_r  <= '0;
      overflow_r <= 1'b0;
      uni_r      <= 1'b1;
    end else begin
      state_r    <= state_nxt;
      mode_r     <= mode_nxt;
      fill_r     <= fill_nxt;
      trimmed_r  <= trimmed_nxt;
      removed_r  <= removed_nxt;
      touched_r  <= touched_nxt;
      segment_r  <= segment_nxt;
      overflow_r <= overflow_nxt;
      if (cfg_wr_en) begin
        uni_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    char_r <= char_nxt;
    eot_r  <= eot_nxt;
  end

endmodule

`default_nettype wire

// ===== hw/rtl/line_whitespace_trimmer.sv =====
// Line whitespace trimmer: drops leading and trailing whitespace of each line
// in a stream of 16-bit code units. Instantiates lwt_ctrl, lwt_ram, lwt_out_reg.
//
// Usage:
// - Input channel (in_valid/in_stall) carries one code unit per transaction,
//   with in_char_valid and in_end_of_text. in_char_valid low with
//   in_end_of_text high is an empty end marker.
// - Result channel (out_valid/out_stall) carries kept code units and, after
//   the last input of a text, one summary transaction with saturating counts
//   and out_last_result high.
// - cfg_wr_en/cfg_wr_data write unicode_space_mode; write only while idle.
// - Output: every result is held in the output register lwt_out_reg before it
//   appears on the result channel.
// - Throughput: one input per cycle while no held whitespace is released and
//   out_stall is low. A content unit that releases held units stalls input
//   while the sequencer reads each one from the pending RAM and emits it,
//   then emits the content unit. An end-of-text input adds a summary step.
// - Reset clears the sequencer state, line mode, fill level and counters and
//   sets unicode_space_mode; the pending RAM needs no clearing pass.
// - When out_stall is high while a result is valid, the result register holds and in_stall rises.
`default_nettype none

module line_whitespace_trimmer #(
  parameter int PENDING_DEPTH = lwt_pkg::PENDING_DEPTH_DEF,
  parameter int COUNT_WIDTH   = lwt_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic        cfg_wr_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_char_valid,
  input  wire logic [15:0] in_character,
  input  wire logic        in_end_of_text,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_is_summary,
  output logic [15:0]      out_character,
  output logic [31:0]      out_removed_count,
  output logic [31:0]      out_touched_lines,
  output logic [31:0]      out_segment_count,
  output logic             out_pending_overflow,
  output logic             out_last_result
);

  import lwt_pkg::*;

  localparam int AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;

  logic          out_free;
  logic          res_load;
  result_t       res;
  result_t       res_q;
  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  logic [15:0]   ram_wr_data;
  logic          ram_rd_en;
  logic [AW-1:0] ram_rd_addr;
  logic [15:0]   ram_rd_data;

  lwt_ctrl #(
    .PENDING_DEPTH (PENDING_DEPTH),
    .COUNT_WIDTH   (COUNT_WIDTH)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_char_valid  (in_char_valid),
    .in_character   (in_character),
    .in_end_of_text (in_end_of_text),
    .in_stall       (in_stall),
    .out_free       (out_free),
    .res_load       (res_load),
    .res            (res),
    .ram_wr_en      (ram_wr_en),
    .ram_wr_addr    (ram_wr_addr),
    .ram_wr_data    (ram_wr_data),
    .ram_rd_en      (ram_rd_en),
    .ram_rd_addr    (ram_rd_addr),
    .ram_rd_data    (ram_rd_data)
  );

  lwt_ram #(
    .WIDTH (16),
    .DEPTH (PENDING_DEPTH)
  ) u_pending_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  lwt_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_load),
    .din       (res),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .dout      (res_q),
    .free      (out_free)
  );

  assign out_is_summary       = res_q.is_summary;
  assign out_character        = res_q.character;
  assign out_removed_count    = res_q.removed_count;
  assign out_touched_lines    = res_q.touched_lines;
  assign out_segment_count    = res_q.segment_count;
  assign out_pending_overflow = res_q.pending_overflow;
  assign out_last_result      = res_q.last_result;

endmodule

`default_nettype wire
